// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PS2MPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, during reset too.
`define PS2MPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/ps2mpt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Types and constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int BYTE_W     = 8;
  localparam int BTN_W      = 3;
  localparam int LIMIT_W    = 12;
  localparam int OUT_W      = 12;
  localparam int SYNC_BIT   = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL    = 2;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd1023;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd767;

  typedef enum logic {
    REG_X_LIMIT = 1'b0,
    REG_Y_LIMIT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    POS_SYNC = 2'd0,
    POS_X    = 2'd1,
    POS_Y    = 2'd2
  } pos_e;

  typedef struct packed {
    logic [BTN_W-1:0]  buttons;
    logic [BYTE_W-1:0] x_delta;
    logic [BYTE_W-1:0] y_delta;
  } pkt_t;

  typedef struct packed {
    logic [OUT_W-1:0] x_pos;
    logic [OUT_W-1:0] y_pos;
    logic [BTN_W-1:0] buttons;
  } res_t;

endpackage

// File: rtl/ps2mpt_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ps2mpt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/ps2mpt_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker front end
// Checks the sync byte and gathers three bytes into one packet.
// ----------------------------------------------------------------------------
module ps2mpt_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]       data_byte_i,
  output logic                                pkt_push_o,
  output ps2mpt_pkg::pkt_t                    pkt_o,
  input  logic                                pkt_full_i
);

  ps2mpt_pkg::pos_e                    pos_q, pos_d;
  logic [ps2mpt_pkg::BTN_W-1:0]        btn_q, btn_d;
  logic [ps2mpt_pkg::BYTE_W-1:0]       xd_q, xd_d;
  logic                                beat;

  assign full = pkt_full_i;
  assign beat = push && !pkt_full_i;

  always_comb begin
    pos_d      = pos_q;
    btn_d      = btn_q;
    xd_d       = xd_q;
    pkt_push_o = 1'b0;
    pkt_o      = '{buttons: btn_q, x_delta: xd_q, y_delta: data_byte_i};
    if (beat) begin
      case (pos_q)
        ps2mpt_pkg::POS_X: begin
          xd_d  = data_byte_i;
          pos_d = ps2mpt_pkg::POS_Y;
        end
        ps2mpt_pkg::POS_Y: begin
          pkt_push_o = 1'b1;
          pos_d      = ps2mpt_pkg::POS_SYNC;
        end
        default: begin
          if (data_byte_i[ps2mpt_pkg::SYNC_BIT]) begin
            btn_d = data_byte_i[ps2mpt_pkg::BTN_W-1:0];
            pos_d = ps2mpt_pkg::POS_X;
          end else begin
            pos_d = ps2mpt_pkg::POS_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= ps2mpt_pkg::POS_SYNC;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    btn_q <= btn_d;
    xd_q  <= xd_d;
  end

endmodule

// File: rtl/ps2mpt_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker back end
// Adds packet deltas to the positions and clamps them to the limits.
// ----------------------------------------------------------------------------
module ps2mpt_back #(
  parameter int POS_WIDTH = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]      x_limit_i,
  input  logic [ps2mpt_pkg::LIMIT_W-1:0]      y_limit_i,
  input  logic                                pkt_empty_i,
  input  ps2mpt_pkg::pkt_t                    pkt_i,
  output logic                                pkt_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output ps2mpt_pkg::res_t                    res_o
);

  localparam int LimW = ps2mpt_pkg::LIMIT_W;
  localparam int OutW = ps2mpt_pkg::OUT_W;
  localparam int SW   = ((POS_WIDTH > LimW) ? POS_WIDTH : LimW) + 2;
  localparam logic signed [SW-1:0] POS_MAX = SW'((1 << POS_WIDTH) - 1);

  logic [POS_WIDTH-1:0] x_acc_q, x_acc_d;
  logic [POS_WIDTH-1:0] y_acc_q, y_acc_d;

  function automatic logic [POS_WIDTH-1:0] apply_delta(
    input logic [POS_WIDTH-1:0]            acc,
    input logic [ps2mpt_pkg::BYTE_W-1:0]   delta,
    input logic [ps2mpt_pkg::LIMIT_W-1:0]  limit
  );
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] sum;
    lim = $signed(SW'(limit));
    if (lim > POS_MAX) begin
      lim = POS_MAX;
    end
    sum = $signed(SW'(acc)) + SW'($signed(delta));
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > lim) begin
      sum = lim;
    end
    return POS_WIDTH'(sum);
  endfunction

  assign pkt_pop_o  = !pkt_empty_i && !res_full_i;
  assign res_push_o = pkt_pop_o;

  always_comb begin
    x_acc_d       = apply_delta(x_acc_q, pkt_i.x_delta, x_limit_i);
    y_acc_d       = apply_delta(y_acc_q, pkt_i.y_delta, y_limit_i);
    res_o.x_pos   = OutW'(x_acc_d);
    res_o.y_pos   = OutW'(y_acc_d);
    res_o.buttons = pkt_i.buttons;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q <= '0;
      y_acc_q <= '0;
    end else if (pkt_pop_o) begin
      x_acc_q <= x_acc_d;
      y_acc_q <= y_acc_d;
    end
  end

endmodule

// File: rtl/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// A packet's result passes through the packet queue and then the result queue.
// Throughput: one byte per cycle; input stalls only when a blocked result side
// fills the packet queue.
// Reset clears packet position, positions and queues; limits return to 1023/767.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
  parameter int POS_WIDTH = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]       data_byte_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [ps2mpt_pkg::OUT_W-1:0]        x_position_o,
  output logic [ps2mpt_pkg::OUT_W-1:0]        y_position_o,
  output logic [ps2mpt_pkg::BTN_W-1:0]        button_bits_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ps2mpt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ps2mpt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ps2mpt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int LimW  = ps2mpt_pkg::LIMIT_W;
  localparam int DataW = ps2mpt_pkg::APB_DATA_W;

  logic [LimW-1:0]   x_limit_q, x_limit_d;
  logic [LimW-1:0]   y_limit_q, y_limit_d;
  ps2mpt_pkg::reg_e  reg_sel;
  logic              cfg_wr;

  logic              pkt_push, pkt_full, pkt_pop, pkt_empty;
  ps2mpt_pkg::pkt_t  pkt_in, pkt_out;
  logic              res_push, res_full;
  ps2mpt_pkg::res_t  res_in, res_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = ps2mpt_pkg::reg_e'(paddr[ps2mpt_pkg::REG_SEL]);

  always_comb begin
    x_limit_d = x_limit_q;
    y_limit_d = y_limit_q;
    prdata    = DataW'(x_limit_q);
    case (reg_sel)
      ps2mpt_pkg::REG_X_LIMIT: begin
        prdata = DataW'(x_limit_q);
        if (cfg_wr) begin
          x_limit_d = pwdata[LimW-1:0];
        end
      end
      ps2mpt_pkg::REG_Y_LIMIT: begin
        prdata = DataW'(y_limit_q);
        if (cfg_wr) begin
          y_limit_d = pwdata[LimW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= ps2mpt_pkg::X_LIMIT_RST;
      y_limit_q <= ps2mpt_pkg::Y_LIMIT_RST;
    end else begin
      x_limit_q <= x_limit_d;
      y_limit_q <= y_limit_d;
    end
  end

  ps2mpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .pkt_push_o  (pkt_push),
    .pkt_o       (pkt_in),
    .pkt_full_i  (pkt_full)
  );

  ps2mpt_fifo #(
    .WIDTH ($bits(ps2mpt_pkg::pkt_t)),
    .DEPTH (2)
  ) u_pkt_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pkt_push),
    .data_i  (pkt_in),
    .full_o  (pkt_full),
    .pop_i   (pkt_pop),
    .data_o  (pkt_out),
    .empty_o (pkt_empty)
  );

  ps2mpt_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .x_limit_i   (x_limit_q),
    .y_limit_i   (y_limit_q),
    .pkt_empty_i (pkt_empty),
    .pkt_i       (pkt_out),
    .pkt_pop_o   (pkt_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  ps2mpt_fifo #(
    .WIDTH ($bits(ps2mpt_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign x_position_o  = res_out.x_pos;
  assign y_position_o  = res_out.y_pos;
  assign button_bits_o = res_out.buttons;

endmodule

// File: rtl/ps2mpt_checker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2mpt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                empty,
  input logic                                pop,
  input logic [ps2mpt_pkg::OUT_W-1:0]        x_position_o,
  input logic [ps2mpt_pkg::OUT_W-1:0]        y_position_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [ps2mpt_pkg::APB_ADDR_W-1:0]   paddr,
  input logic [ps2mpt_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [ps2mpt_pkg::APB_DATA_W-1:0]   prdata,
  input logic                                pready
);

  localparam int LimW = ps2mpt_pkg::LIMIT_W;

  logic [LimW-1:0] xlim_q;
  logic [LimW-1:0] ylim_q;
  logic            wr_beat;
  logic            sel_y;

  assign wr_beat = psel && penable && pwrite && pready;
  assign sel_y   = paddr[ps2mpt_pkg::REG_SEL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlim_q <= ps2mpt_pkg::X_LIMIT_RST;
      ylim_q <= ps2mpt_pkg::Y_LIMIT_RST;
    end else if (wr_beat) begin
      if (sel_y) begin
        ylim_q <= pwdata[LimW-1:0];
      end else begin
        xlim_q <= pwdata[LimW-1:0];
      end
    end
  end

  `PS2MPT_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |=> empty, "result shown during reset")
  `PS2MPT_ASSERT(a_x_in_limit, !empty |-> x_position_o <= xlim_q, "x position above limit")
  `PS2MPT_ASSERT(a_y_in_limit, !empty |-> y_position_o <= ylim_q, "y position above limit")
  `PS2MPT_ASSERT(a_read_back, psel && !sel_y |-> prdata[LimW-1:0] == xlim_q, "x limit readback")
  `PS2MPT_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(x_position_o), "result changed")

endmodule

bind ps2_mouse_packet_tracker ps2mpt_checker u_ps2mpt_checker (.*);

// File: tb/ps2_mouse_packet_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker checker
// Watches the byte, result and register channels of the tracker. It keeps its
// own copy of the packet position, the deltas, the positions and the limits,
// predicts one pointer report per complete packet and compares every popped
// beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_checker
  import ps2mpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  logic                  full,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [OUT_W-1:0]      x_position_o,
  input  logic [OUT_W-1:0]      y_position_o,
  input  logic [BTN_W-1:0]      button_bits_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    pending_o,
  output int                    errors_o
);

  logic [LIMIT_W-1:0] x_limit_q = X_LIMIT_RST;
  logic [LIMIT_W-1:0] y_limit_q = Y_LIMIT_RST;
  pos_e               packet_slot = POS_SYNC;
  logic [BTN_W-1:0]   held_buttons = '0;
  logic [BYTE_W-1:0]  x_step = '0;
  logic [BYTE_W-1:0]  y_step = '0;
  logic [OUT_W-1:0]   x_pos = '0;
  logic [OUT_W-1:0]   y_pos = '0;
  res_t               pointer_reports[$];
  res_t               report;
  res_t               due;
  int                 mismatches = 0;

  function automatic logic [OUT_W-1:0] move_axis(input logic [OUT_W-1:0]   pos,
                                                 input logic [BYTE_W-1:0]  delta,
                                                 input logic [LIMIT_W-1:0] limit);
    int sum;
    sum = int'(pos) + int'($signed(delta));
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > int'(limit)) begin
      sum = int'(limit);
    end
    return sum[OUT_W-1:0];
  endfunction

  task automatic track_byte(input logic [BYTE_W-1:0] b);
    case (packet_slot)
      POS_X: begin
        x_step      = b;
        packet_slot = POS_Y;
      end
      POS_Y: begin
        y_step      = b;
        packet_slot = POS_SYNC;
        x_pos       = move_axis(x_pos, x_step, x_limit_q);
        y_pos       = move_axis(y_pos, y_step, y_limit_q);
        report.x_pos   = x_pos;
        report.y_pos   = y_pos;
        report.buttons = held_buttons;
        pointer_reports.push_back(report);
      end
      default: begin
        // A first byte without the sync bit is dropped.
        if (b[SYNC_BIT]) begin
          held_buttons = b[BTN_W-1:0];
          packet_slot  = POS_X;
        end else begin
          packet_slot = POS_SYNC;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q    = X_LIMIT_RST;
      y_limit_q    = Y_LIMIT_RST;
      packet_slot  = POS_SYNC;
      held_buttons = '0;
      x_step       = '0;
      y_step       = '0;
      x_pos        = '0;
      y_pos        = '0;
      pointer_reports.delete();
    end else begin
      if (pop && !empty) begin
        if (pointer_reports.size() == 0) begin
          $display("%0t: result expected none, actual x=%0d y=%0d buttons=%0d",
                   $time, x_position_o, y_position_o, button_bits_o);
          mismatches++;
        end else begin
          due = pointer_reports.pop_front();
          compare_field("x_position", due.x_pos, x_position_o);
          compare_field("y_position", due.y_pos, y_position_o);
          compare_field("button_bits", OUT_W'(due.buttons), OUT_W'(button_bits_o));
        end
      end
      if (push && !full) begin
        track_byte(data_byte_i);
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[REG_SEL]))
          REG_X_LIMIT: x_limit_q = pwdata[LIMIT_W-1:0];
          REG_Y_LIMIT: y_limit_q = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o <= pointer_reports.size();
    errors_o  <= mismatches;
  end

endmodule

// File: tb/ps2_mouse_packet_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Feeds mouse bytes through the push side: a short directed set of packets and
// bad sync bytes, then phases of random packets mixed with stray bytes, each
// phase under new clamp limits written over the register port while idle.
// Both sides idle in random bursts; the checker judges every result beat.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_test;
  import ps2mpt_pkg::*;

  typedef enum int {
    DRIFT_NONE,
    DRIFT_UP,
    DRIFT_DOWN
  } drift_e;

  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 190;
  localparam int STALL_LIMIT   = 2000;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  push    = 1'b0;
  logic [BYTE_W-1:0]     data_byte_i = '0;
  logic                  pop     = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic                  full;
  logic                  empty;
  logic                  pready;
  logic [APB_DATA_W-1:0] prdata;
  logic [OUT_W-1:0]      x_position_o;
  logic [OUT_W-1:0]      y_position_o;
  logic [BTN_W-1:0]      button_bits_o;
  logic                  calm = 1'b0;
  int                    pop_stall = 0;
  int                    quiet_cycles = 0;
  int                    pending_count;
  int                    mismatches;

  always #10 clk_i = ~clk_i;

  ps2_mouse_packet_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .x_position_o  (x_position_o),
    .y_position_o  (y_position_o),
    .button_bits_o (button_bits_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ps2_mouse_packet_tracker_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .x_position_o  (x_position_o),
    .y_position_o  (y_position_o),
    .button_bits_o (button_bits_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending_o     (pending_count),
    .errors_o      (mismatches)
  );

  always @(posedge clk_i) begin
    if (pop_stall > 0) begin
      pop       <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop       <= 1'b0;
      pop_stall <= $urandom_range(0, 4);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("** ps2_mouse_packet_tracker: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    send_byte(head);
    send_byte(dx);
    send_byte(dy);
  endtask

  task automatic write_limit(input reg_e which, input logic [LIMIT_W-1:0] limit);
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {(APB_DATA_W - LIMIT_W)'($urandom), limit};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return LIMIT_W'($urandom_range(0, 63));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_delta(input drift_e drift);
    case (drift)
      DRIFT_UP:   return BYTE_W'($urandom_range(32, 127));
      DRIFT_DOWN: return BYTE_W'($urandom_range(128, 224));
      default:    return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    int                sent;
    drift_e            drift;
    logic [BYTE_W-1:0] head;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bad sync bytes first, then the largest and smallest deltas.
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h0F, 8'h7F, 8'h7F);
    send_packet(8'h08, 8'h80, 8'h80);
    send_packet(8'hFF, 8'h00, 8'hFF);

    write_limit(REG_X_LIMIT, '0);
    write_limit(REG_Y_LIMIT, '1);
    send_packet(8'h0A, 8'h7F, 8'h7F);

    // The y limit drops below the current y position.
    write_limit(REG_X_LIMIT, '1);
    write_limit(REG_Y_LIMIT, '0);
    send_packet(8'h0C, 8'h01, 8'h00);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_limit(REG_X_LIMIT, pick_limit());
      write_limit(REG_Y_LIMIT, pick_limit());
      if (phase == RANDOM_PHASES - 1) begin
        calm <= 1'b1;
      end
      drift = drift_e'($urandom_range(0, 2));
      sent  = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_byte(BYTE_W'($urandom));
        end else begin
          head           = BYTE_W'($urandom);
          head[SYNC_BIT] = 1'b1;
          send_packet(head, pick_delta(drift), pick_delta(drift));
          sent += 3;
        end
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** ps2_mouse_packet_tracker: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_fifo.sv
rtl/ps2mpt_front.sv
rtl/ps2mpt_back.sv
rtl/ps2_mouse_packet_tracker.sv
rtl/ps2mpt_checker.sv
tb/ps2_mouse_packet_tracker_checker.sv
tb/ps2_mouse_packet_tracker_test.sv
